@@ src/bkb_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyboard buffer service package
// Shared operation codes, field widths, modifier key codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bkb_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [2:0] OP_PRESS      = 3'd0;
	localparam logic [2:0] OP_READ       = 3'd1;
	localparam logic [2:0] OP_STATUS     = 3'd2;
	localparam logic [2:0] OP_SHIFT      = 3'd3;
	localparam logic [2:0] OP_STORE      = 3'd4;
	localparam logic [2:0] OP_SET_BIT    = 3'd5;
	localparam logic [2:0] OP_CLEAR_BIT  = 3'd6;
	localparam logic [2:0] OP_CLEAR_BYTE = 3'd7;

	// Field widths.
	localparam int OP_W    = 3;
	localparam int KEY_W   = 16;
	localparam int FLAG_W  = 8;
	localparam int FBIT_W  = 3;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 40;

	// Modifier keys that a status peek reports as zero.
	localparam logic [KEY_W-1:0] KEY_CTRL  = 16'h1d00;
	localparam logic [KEY_W-1:0] KEY_SHIFT = 16'h2a00;
	localparam logic [KEY_W-1:0] KEY_ALT   = 16'h3800;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the accepted input word
		logic exec;  // perform the operation and load the result register
	} bkb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // result register empty or being taken this cycle
	} bkb_stat_t;

endpackage

@@ src/bios_keyboard_buffer_service_unit.sv @@
// ----------------------------------------------------------------------------
// BIOS keyboard buffer service unit
// Ring buffer of key codes with two flag bytes, one operation per word.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one operation per word: tuser holds the
//   operation code, tdata the key code, flag byte select and flag bit.
//   Every accepted word yields exactly one result word on the master
//   stream, in order.
//   A word is accepted in the idle state and executed in the execute
//   state once the output register is free, which loads the result
//   register; no new word is taken until it has executed. The ring lives in a
//   RAM with registered read, which the execute cycle consumes.
//   When the receiver stalls, the pending result stays in the output
//   register and one further word is still accepted; it waits in the
//   execute state until the output register frees up.
//   Reset clears the indexes, both flag bytes and the result valid flag; ring
//   contents are not cleared since only entries between head and tail
//   are ever read.
// ----------------------------------------------------------------------------
module bios_keyboard_buffer_service_unit #(
	parameter int RING_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] key_code, [16] flag_byte, [19:17] flag_bit, [23:20] zero
	input  logic [23:0] s_tdata,
	// [2:0] op
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] key_value, [16] buffer_empty, [17] push_failed,
	// [25:18] shift_flags, [33:26] extra_flags, [34] raise_irq, [39:35] zero
	output logic [39:0] m_tdata
);
	import bkb_pkg::*;

	bkb_cmd_t  cmd;
	bkb_stat_t stat;

	logic [KEY_W-1:0]  key_value;
	logic              buffer_empty;
	logic              push_failed;
	logic [FLAG_W-1:0] shift_flags;
	logic [FLAG_W-1:0] extra_flags;
	logic              raise_irq;

	// Controller.
	bkb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath.
	bkb_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (s_tuser),
		.key_code     (s_tdata[15:0]),
		.flag_byte    (s_tdata[16]),
		.flag_bit     (s_tdata[19:17]),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.key_value    (key_value),
		.buffer_empty (buffer_empty),
		.push_failed  (push_failed),
		.shift_flags  (shift_flags),
		.extra_flags  (extra_flags),
		.raise_irq    (raise_irq)
	);

	// Pack the result word.
	assign m_tdata = {5'b0, raise_irq, extra_flags, shift_flags,
	                  push_failed, buffer_empty, key_value};

endmodule

@@ src/bkb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bkb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	assign rdata = rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

@@ src/bkb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Keyboard buffer controller
// Two-state sequencer: accept one word, then execute it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
module bkb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  bkb_pkg::bkb_stat_t stat,
	output bkb_pkg::bkb_cmd_t  cmd
);
	import bkb_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/bkb_dp.sv @@
// ----------------------------------------------------------------------------
// Keyboard buffer datapath
// Holds the key ring, head and tail indexes, both flag bytes, the captured
// input word and the result register.
// ----------------------------------------------------------------------------
module bkb_dp #(
	parameter int RING_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bkb_pkg::bkb_cmd_t            cmd,
	output bkb_pkg::bkb_stat_t           stat,
	input  logic [bkb_pkg::OP_W-1:0]     op,
	input  logic [bkb_pkg::KEY_W-1:0]    key_code,
	input  logic                         flag_byte,
	input  logic [bkb_pkg::FBIT_W-1:0]   flag_bit,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [bkb_pkg::KEY_W-1:0]    key_value,
	output logic                         buffer_empty,
	output logic                         push_failed,
	output logic [bkb_pkg::FLAG_W-1:0]   shift_flags,
	output logic [bkb_pkg::FLAG_W-1:0]   extra_flags,
	output logic                         raise_irq
);
	import bkb_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

	// Captured input word.
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  code_q;
	logic              fsel_q;
	logic [FBIT_W-1:0] fbit_q;

	// Ring state.
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [FLAG_W-1:0] flag1_q;
	logic [FLAG_W-1:0] flag2_q;
	logic [KEY_W-1:0]  head_key;

	// Result register.
	logic              ovalid_q;
	logic [KEY_W-1:0]  kv_q;
	logic              empty_q;
	logic              failed_q;
	logic [FLAG_W-1:0] shift_q;
	logic [FLAG_W-1:0] extra_q;
	logic              irq_q;

	// Combinational results.
	logic [IDX_W-1:0]  head_nx;
	logic [IDX_W-1:0]  tail_nx;
	logic              ring_empty;
	logic              ring_full;
	logic              is_push;
	logic              is_peek;
	logic              do_write;
	logic [FLAG_W-1:0] bit_mask;
	logic [FLAG_W-1:0] sel_flag;
	logic [FLAG_W-1:0] new_flag;
	logic [FLAG_W-1:0] flag1_d;
	logic [FLAG_W-1:0] flag2_d;
	logic [KEY_W-1:0]  kv_d;
	logic              empty_d;

	assign stat.out_free = !ovalid_q || res_ready;
	assign res_valid     = ovalid_q;
	assign key_value     = kv_q;
	assign buffer_empty  = empty_q;
	assign push_failed   = failed_q;
	assign shift_flags   = shift_q;
	assign extra_flags   = extra_q;
	assign raise_irq     = irq_q;

	// The head entry is read every cycle, so its data is current by the
	// execute cycle: the head moves only while executing.
	bkb_ram #(
		.WIDTH (KEY_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (do_write),
		.waddr (tail_q),
		.wdata (code_q),
		.raddr (head_q),
		.rdata (head_key)
	);

	// Index arithmetic and operation decode.
	always_comb begin
		head_nx    = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
		tail_nx    = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
		ring_empty = (head_q == tail_q);
		ring_full  = (tail_nx == head_q);
		is_push    = (op_q == OP_PRESS) || (op_q == OP_STORE);
		is_peek    = (op_q == OP_READ) || (op_q == OP_STATUS);
		do_write   = cmd.exec && is_push && !ring_full;
	end

	// Flag byte update.
	always_comb begin
		bit_mask = FLAG_W'(1) << fbit_q;
		sel_flag = fsel_q ? flag2_q : flag1_q;
		case (op_q)
			OP_SET_BIT:    new_flag = sel_flag | bit_mask;
			OP_CLEAR_BIT:  new_flag = sel_flag & ~bit_mask;
			OP_CLEAR_BYTE: new_flag = '0;
			default:       new_flag = sel_flag;
		endcase
		flag1_d = fsel_q ? flag1_q : new_flag;
		flag2_d = fsel_q ? new_flag : flag2_q;
	end

	// Key value for read and status.
	always_comb begin
		empty_d = is_peek && ring_empty;
		kv_d    = '0;
		if (is_peek && !ring_empty) begin
			if (op_q == OP_STATUS &&
			    (head_key == KEY_CTRL || head_key == KEY_SHIFT || head_key == KEY_ALT)) begin
				kv_d = '0;
			end else begin
				kv_d = head_key;
			end
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			code_q <= key_code;
			fsel_q <= flag_byte;
			fbit_q <= flag_bit;
		end
	end

	// Ring indexes and flag bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			flag1_q <= '0;
			flag2_q <= '0;
		end else if (cmd.exec) begin
			if (do_write) begin
				tail_q <= tail_nx;
			end
			if (op_q == OP_READ && !ring_empty) begin
				head_q <= head_nx;
			end
			flag1_q <= flag1_d;
			flag2_q <= flag2_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.exec) begin
			ovalid_q <= 1'b1;
		end else if (res_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			kv_q     <= kv_d;
			empty_q  <= empty_d;
			failed_q <= is_push && ring_full;
			shift_q  <= flag1_d;
			extra_q  <= flag2_d;
			irq_q    <= (op_q == OP_PRESS) || (op_q == OP_READ);
		end
	end

endmodule
